### sv/stream_find_and_replace_assert.svh
// Assertion helpers for the find-and-replace block.
`ifndef STREAM_FIND_AND_REPLACE_ASSERT_SVH
`define STREAM_FIND_AND_REPLACE_ASSERT_SVH

`ifndef SYNTHESIS

`define SFR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfr: same-cycle check failed");

`define SFR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfr: next-cycle check failed");

`else

`define SFR_ASSERT_SAME(lbl, clk, rst, ante, cons)

`define SFR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### sv/sfr_pkg.sv
package sfr_pkg;

   localparam int BYTE_W    = 8;
   localparam int WORD_W    = 64;
   localparam int LEN_W     = 4;
   localparam int CNT_W     = 4;
   localparam int CSR_IDX_W = 8;

   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_BYTES      = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PATTERN_LENGTH     = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACEMENT_BYTES  = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 8'd3;

   // Describes the run of results that one accepted byte produces.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             present;
      logic             eot;
   } sfr_list_type;

endpackage

### sv/sfr_req_if.sv
interface sfr_req_if;
   import sfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              end_of_text;

   modport source (output valid, output data_byte, output end_of_text, input ready);
   modport sink (input valid, input data_byte, input end_of_text, output ready);
endinterface

### sv/sfr_rsp_if.sv
interface sfr_rsp_if;
   import sfr_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              byte_present;
   logic              last_of_run;
   logic              end_of_output;

   modport source (output valid, output out_byte, output byte_present,
                   output last_of_run, output end_of_output, input ready);
   modport sink (input valid, input out_byte, input byte_present,
                 input last_of_run, input end_of_output, output ready);
endinterface

### sv/sfr_csr_if.sv
interface sfr_csr_if;
   import sfr_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

### sv/stream_find_and_replace.sv
// Streaming find-and-replace.
// req_if  : one text byte per transaction, end_of_text on the final byte of a text.
// rsp_if  : one rewritten byte per transaction; last_of_run closes the results of one
//           input byte, end_of_output closes the text. An input byte that ends a text
//           but leaves nothing to send produces one empty marker (byte_present low).
// csr_if  : register writes (0 pattern, 1 pattern length, 2 replacement, 3 replacement
//           length); always ready. Write only while the block is idle; it is not enforced.
// Path    : an input byte is matched in the cycle it is taken; its results are
//           registered in a run buffer and leave it through the output register.
// Rate    : one result per cycle on rsp_if while rsp_if.ready is high. A byte with
//           zero or one result is taken every cycle unless the output stalls; a
//           byte with more results (up to the larger of the two length limits)
//           holds the input while the run buffer drains.
// Stall   : when rsp_if.ready is low the output register holds its result; the run
//           buffer still takes the next byte if it is empty, then input stops.
// Reset   : synchronous; clears the window, the buffers and all registers to zero.
`include "stream_find_and_replace_assert.svh"

module stream_find_and_replace #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input logic       clock,
   input logic       reset,
   sfr_req_if.sink   req_if,
   sfr_rsp_if.source rsp_if,
   sfr_csr_if.sink   csr_if
);
   import sfr_pkg::*;

   localparam int RES_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;

   logic [WORD_W-1:0] pattern_bytes_ff, replacement_bytes_ff;
   logic [LEN_W-1:0]  pattern_length_ff, replacement_length_ff;

   logic [RES_MAX-1:0][BYTE_W-1:0] list_bytes;
   sfr_list_type                   list_info;

   logic [RES_MAX-1:0][BYTE_W-1:0] buf_ff, buf_in;
   logic [CNT_W-1:0]               buf_cnt_ff, buf_cnt_in;
   logic                           buf_present_ff, buf_present_in;
   logic                           buf_eot_ff, buf_eot_in;

   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_present_ff, out_present_in;
   logic              out_last_ff, out_last_in;
   logic              out_end_ff, out_end_in;

   logic move, pop, accept;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_bytes_ff      <= '0;
         pattern_length_ff     <= '0;
         replacement_bytes_ff  <= '0;
         replacement_length_ff <= '0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_PATTERN_BYTES:      pattern_bytes_ff      <= csr_if.data;
            REG_PATTERN_LENGTH:     pattern_length_ff     <= csr_if.data[LEN_W-1:0];
            REG_REPLACEMENT_BYTES:  replacement_bytes_ff  <= csr_if.data;
            REG_REPLACEMENT_LENGTH: replacement_length_ff <= csr_if.data[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign move   = !out_valid_ff || rsp_if.ready;
   assign pop    = move && (buf_cnt_ff != '0);
   assign req_if.ready = (buf_cnt_ff == '0) || (buf_cnt_ff == CNT_W'(1) && move);
   assign accept = req_if.valid && req_if.ready;

   sfr_window #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_window (
      .clock              (clock),
      .reset              (reset),
      .step_en            (accept),
      .data_byte          (req_if.data_byte),
      .end_of_text        (req_if.end_of_text),
      .pattern_bytes      (pattern_bytes_ff),
      .pattern_length     (pattern_length_ff),
      .replacement_bytes  (replacement_bytes_ff),
      .replacement_length (replacement_length_ff),
      .list_bytes         (list_bytes),
      .list_info          (list_info)
   );

   always_comb begin
      buf_in         = buf_ff;
      buf_cnt_in     = buf_cnt_ff;
      buf_present_in = buf_present_ff;
      buf_eot_in     = buf_eot_ff;
      if (accept) begin
         // buffer is empty or hands its last entry on in this cycle
         buf_in         = list_bytes;
         buf_cnt_in     = list_info.count;
         buf_present_in = list_info.present;
         buf_eot_in     = list_info.eot;
      end else if (pop) begin
         for (int i = 0; i < RES_MAX - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         buf_in[RES_MAX-1] = '0;
         buf_cnt_in = buf_cnt_ff - CNT_W'(1);
      end

      out_valid_in   = out_valid_ff;
      out_byte_in    = out_byte_ff;
      out_present_in = out_present_ff;
      out_last_in    = out_last_ff;
      out_end_in     = out_end_ff;
      if (move) begin
         out_valid_in   = buf_cnt_ff != '0;
         out_byte_in    = buf_ff[0];
         out_present_in = buf_present_ff;
         out_last_in    = buf_cnt_ff == CNT_W'(1);
         out_end_in     = buf_eot_ff && (buf_cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff         <= '0;
         buf_cnt_ff     <= '0;
         buf_present_ff <= 1'b0;
         buf_eot_ff     <= 1'b0;
         out_valid_ff   <= 1'b0;
         out_byte_ff    <= '0;
         out_present_ff <= 1'b0;
         out_last_ff    <= 1'b0;
         out_end_ff     <= 1'b0;
      end else begin
         buf_ff         <= buf_in;
         buf_cnt_ff     <= buf_cnt_in;
         buf_present_ff <= buf_present_in;
         buf_eot_ff     <= buf_eot_in;
         out_valid_ff   <= out_valid_in;
         out_byte_ff    <= out_byte_in;
         out_present_ff <= out_present_in;
         out_last_ff    <= out_last_in;
         out_end_ff     <= out_end_in;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.out_byte      = out_byte_ff;
   assign rsp_if.byte_present  = out_present_ff;
   assign rsp_if.last_of_run   = out_last_ff;
   assign rsp_if.end_of_output = out_end_ff;

   `SFR_ASSERT_SAME(a_buf_bound, clock, reset, 1'b1, buf_cnt_ff <= CNT_W'(RES_MAX))
   `SFR_ASSERT_NEXT(a_eot_loads, clock, reset, accept && req_if.end_of_text,
                    buf_cnt_ff != '0 && buf_eot_ff)
   `SFR_ASSERT_SAME(a_marker, clock, reset, out_valid_ff && !out_present_ff,
                    out_byte_ff == '0 && out_end_ff && out_last_ff)
endmodule

### sv/sfr_window.sv
module sfr_window #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [sfr_pkg::BYTE_W-1:0]    data_byte,
   input  logic                          end_of_text,
   input  logic [sfr_pkg::WORD_W-1:0]    pattern_bytes,
   input  logic [sfr_pkg::LEN_W-1:0]     pattern_length,
   input  logic [sfr_pkg::WORD_W-1:0]    replacement_bytes,
   input  logic [sfr_pkg::LEN_W-1:0]     replacement_length,
   output logic [((PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX)-1:0]
                [sfr_pkg::BYTE_W-1:0]    list_bytes,
   output sfr_pkg::sfr_list_type         list_info
);
   import sfr_pkg::*;

   localparam int RES_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
   localparam int FILL_W  = $clog2(PATTERN_MAX + 1);
   localparam int RLEN_W  = $clog2(REPLACE_MAX + 1);

   logic [PATTERN_MAX-1:0][BYTE_W-1:0] win_ff, win_in;
   logic [FILL_W-1:0]                  fill_ff, fill_in;

   logic [PATTERN_MAX-1:0][BYTE_W-1:0] w_ext;
   logic [FILL_W-1:0]                  fill_new, plen_e, target, n_pop;
   logic [RLEN_W-1:0]                  rlen_e;
   logic                               over, full_eq, match, hit;

   always_comb begin
      // window with the new byte appended at the fill position
      w_ext = win_ff;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (FILL_W'(i) == fill_ff) begin
            w_ext[i] = data_byte;
         end
      end
      fill_new = fill_ff + FILL_W'(1);

      plen_e = (pattern_length > LEN_W'(PATTERN_MAX)) ? FILL_W'(PATTERN_MAX)
                                                      : FILL_W'(pattern_length);
      rlen_e = (replacement_length > LEN_W'(REPLACE_MAX)) ? RLEN_W'(REPLACE_MAX)
                                                          : RLEN_W'(replacement_length);
      target = (plen_e == '0) ? '0 : plen_e - FILL_W'(1);

      match = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (FILL_W'(i) < plen_e && w_ext[i] != pattern_bytes[BYTE_W*i +: BYTE_W]) begin
            match = 1'b0;
         end
      end

      over    = fill_new > plen_e;
      full_eq = fill_new == plen_e;
      hit     = full_eq && match;

      if (hit || end_of_text) begin
         n_pop = hit ? '0 : fill_new;
      end else if (over) begin
         n_pop = fill_new - target;
      end else if (full_eq) begin
         n_pop = FILL_W'(1);
      end else begin
         n_pop = '0;
      end

      fill_in = hit ? '0 : fill_new - n_pop;

      // drop the emitted bytes from the front
      win_in = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         for (int k = 0; k <= PATTERN_MAX; k++) begin
            if (FILL_W'(k) == n_pop && i + k < PATTERN_MAX) begin
               win_in[i] = w_ext[(i + k) % PATTERN_MAX];
            end
         end
      end

      list_bytes = '0;
      for (int j = 0; j < RES_MAX; j++) begin
         if (hit) begin
            if (j < REPLACE_MAX) begin
               list_bytes[j] = replacement_bytes[BYTE_W*(j % REPLACE_MAX) +: BYTE_W];
            end
         end else if (j < PATTERN_MAX) begin
            list_bytes[j] = w_ext[j % PATTERN_MAX];
         end
      end

      list_info.count   = hit ? CNT_W'(rlen_e) : CNT_W'(n_pop);
      list_info.present = 1'b1;
      list_info.eot     = end_of_text;
      // empty end marker when the final byte leaves nothing to send
      if (end_of_text && list_info.count == '0) begin
         list_info.count   = CNT_W'(1);
         list_info.present = 1'b0;
         list_bytes        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= '0;
         fill_ff <= '0;
      end else if (step_en) begin
         win_ff  <= win_in;
         fill_ff <= fill_in;
      end
   end
endmodule

### bench/sfr_rewrite_check.sv
`timescale 1ns / 1ps

module sfr_rewrite_check (
   input  logic clock,
   input  logic reset,
   sfr_req_if   req,
   sfr_rsp_if   rsp,
   sfr_csr_if   csr,
   output int   errors,
   output int   pending,
   output int   checked,
   output int   texts_done
);
   import sfr_pkg::*;

   localparam int WINDOW_DEPTH = 8;
   localparam int PATTERN_LIMIT = 8;
   localparam int REPLACE_LIMIT = 8;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              byte_present;
      logic              last_of_run;
      logic              end_of_output;
   } rewrite_type;

   logic [WORD_W-1:0] pattern_word;
   logic [LEN_W-1:0]  pattern_len;
   logic [WORD_W-1:0] replace_word;
   logic [LEN_W-1:0]  replace_len;

   logic [BYTE_W-1:0] window [WINDOW_DEPTH];
   int                window_fill;

   // results of the byte being predicted
   rewrite_type run_buf [16];
   int          run_n;

   rewrite_type rewrite_q [$];
   int          err_count;
   int          check_count;
   int          text_count;

   function automatic logic [BYTE_W-1:0] take_oldest();
      logic [BYTE_W-1:0] b;
      b = window[0];
      for (int i = 0; i < WINDOW_DEPTH - 1; i++) window[i] = window[i + 1];
      window[WINDOW_DEPTH - 1] = '0;
      if (window_fill > 0) window_fill--;
      return b;
   endfunction

   function automatic void add_result(logic [BYTE_W-1:0] b, logic present);
      run_buf[run_n] = '{b, present, 1'b0, 1'b0};
      run_n++;
   endfunction

   task automatic rewrite_byte(input logic [BYTE_W-1:0] b, input logic eot);
      int  plen;
      int  rlen;
      int  target;
      bit  hit;
      plen = (pattern_len > PATTERN_LIMIT) ? PATTERN_LIMIT : int'(pattern_len);
      rlen = (replace_len > REPLACE_LIMIT) ? REPLACE_LIMIT : int'(replace_len);
      run_n = 0;
      if (window_fill > WINDOW_DEPTH - 1) window_fill = WINDOW_DEPTH - 1;
      window[window_fill] = b;
      window_fill++;
      if (window_fill > plen) begin
         // also covers a pattern that shrank while bytes were held
         target = (plen > 0) ? plen - 1 : 0;
         while (window_fill > target) add_result(take_oldest(), 1'b1);
      end else if (window_fill == plen) begin
         hit = 1'b1;
         for (int i = 0; i < plen; i++)
            if (window[i] != pattern_word[8*i +: 8]) hit = 1'b0;
         if (hit) begin
            for (int i = 0; i < rlen; i++) add_result(replace_word[8*i +: 8], 1'b1);
            for (int i = 0; i < WINDOW_DEPTH; i++) window[i] = '0;
            window_fill = 0;
         end else begin
            add_result(take_oldest(), 1'b1);
         end
      end
      if (eot) begin
         while (window_fill > 0) add_result(take_oldest(), 1'b1);
         if (run_n == 0) add_result('0, 1'b0);
         run_buf[run_n - 1].end_of_output = 1'b1;
      end
      if (run_n > 0) run_buf[run_n - 1].last_of_run = 1'b1;
      for (int i = 0; i < run_n; i++) rewrite_q.push_back(run_buf[i]);
   endtask

   function automatic void compare_field(string name, logic [BYTE_W-1:0] want,
                                         logic [BYTE_W-1:0] got);
      if (got !== want) begin
         err_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
   endfunction

   task automatic check_result();
      rewrite_type want;
      rewrite_type got;
      got = {rsp.out_byte, rsp.byte_present, rsp.last_of_run, rsp.end_of_output};
      check_count++;
      if (got.end_of_output === 1'b1) text_count++;
      if (rewrite_q.size() == 0) begin
         err_count++;
         $display("%0t: unexpected result, expected none, actual byte=%h present=%b last=%b end=%b",
                  $time, got.out_byte, got.byte_present, got.last_of_run, got.end_of_output);
      end else begin
         want = rewrite_q.pop_front();
         compare_field("out_byte", want.out_byte, got.out_byte);
         compare_field("byte_present", 8'(want.byte_present), 8'(got.byte_present));
         compare_field("last_of_run", 8'(want.last_of_run), 8'(got.last_of_run));
         compare_field("end_of_output", 8'(want.end_of_output), 8'(got.end_of_output));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_word = '0;
         pattern_len  = '0;
         replace_word = '0;
         replace_len  = '0;
         for (int i = 0; i < WINDOW_DEPTH; i++) window[i] = '0;
         window_fill = 0;
         rewrite_q.delete();
      end else begin
         if (rsp.valid && rsp.ready) check_result();
         if (csr.valid && csr.ready) begin
            case (csr.index)
               REG_PATTERN_BYTES:      pattern_word = csr.data;
               REG_PATTERN_LENGTH:     pattern_len  = csr.data[LEN_W-1:0];
               REG_REPLACEMENT_BYTES:  replace_word = csr.data;
               REG_REPLACEMENT_LENGTH: replace_len  = csr.data[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) rewrite_byte(req.data_byte, req.end_of_text);
      end
      errors     <= err_count;
      pending    <= rewrite_q.size();
      checked    <= check_count;
      texts_done <= text_count;
   end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import sfr_pkg::*;

   localparam int LIMIT_CYCLES = 200000;
   localparam int LONG_HOLD    = 40;
   localparam int TARGET_ITEMS = 410;
   localparam int MAX_GAP      = 6;
   localparam int SETTLE       = 6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 8'hA5;

   logic clock = 1'b0;
   logic reset;

   int errors;
   int pending;
   int checked;
   int texts_done;
   int cycle_count = 0;
   int sent = 0;
   int settings = 0;
   int hold_requests = 0;
   bit idle_on = 1'b1;

   logic [WORD_W-1:0] cfg_pattern;
   int                cfg_plen;
   logic [BYTE_W-1:0] text_q [$];

   sfr_req_if req_ch ();
   sfr_rsp_if rsp_ch ();
   sfr_csr_if csr_ch ();

   stream_find_and_replace dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   sfr_rewrite_check rewrite_check (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .csr        (csr_ch),
      .errors     (errors),
      .pending    (pending),
      .checked    (checked),
      .texts_done (texts_done)
   );

   always #4 clock = ~clock;

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result receiver: random stalls per transaction, long hold-offs on request
   initial begin : result_sink
      int holds_done;
      int gap;
      holds_done = 0;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (holds_done < hold_requests) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end
         gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   // length value with random bits above the length field
   function automatic logic [WORD_W-1:0] with_length(int len);
      logic [WORD_W-1:0] v;
      v = {$urandom, $urandom};
      v[LEN_W-1:0] = len[LEN_W-1:0];
      return v;
   endfunction

   task automatic apply_setting(input logic [WORD_W-1:0] pat, input int plen,
                                input logic [WORD_W-1:0] repl, input int rlen);
      write_reg(REG_PATTERN_BYTES, pat);
      write_reg(REG_PATTERN_LENGTH, with_length(plen));
      write_reg(REG_REPLACEMENT_BYTES, repl);
      write_reg(REG_REPLACEMENT_LENGTH, with_length(rlen));
      cfg_pattern = pat;
      cfg_plen    = plen;
      settings++;
   endtask

   task automatic random_setting();
      logic [WORD_W-1:0] pat;
      int r;
      int plen;
      int rlen;
      pat = {$urandom, $urandom};
      for (int i = 0; i < 8; i++)
         if ($urandom_range(0, 2) != 0) pat[8*i +: 8] = 8'(8'h61 + $urandom_range(0, 2));
      r = $urandom_range(0, 9);
      plen = (r == 0) ? 0 : (r == 9) ? $urandom_range(9, 15) : $urandom_range(1, 8);
      r = $urandom_range(0, 9);
      rlen = (r == 9) ? $urandom_range(9, 15) : $urandom_range(0, 8);
      apply_setting(pat, plen, {$urandom, $urandom}, rlen);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eot);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.end_of_text <= eot;
      do @(posedge clock); while (!req_ch.ready);
      sent++;
   endtask

   // held bytes may still be in flight after the last result, hence the settle time
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin : stimulus
      int tlen;
      int r;
      int eff;
      int cut;
      int tno;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.data_byte   <= '0;
      req_ch.end_of_text <= 1'b0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= '0;
      csr_ch.data        <= '0;
      cfg_pattern = '0;
      cfg_plen    = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero pattern length passes bytes through
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      wait_idle();

      // "ab" -> "XYZ", unused pattern bytes all ones
      apply_setting(64'hFFFF_FFFF_FFFF_6261, 2, 64'h0000_0000_005A_5958, 3);
      send_byte(8'h78, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h79, 1'b1);
      send_byte(8'h61, 1'b1);      // lone held byte flushed by end of text
      send_byte(8'h61, 1'b0);      // false start, then leftmost match
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
      wait_idle();

      // zero replacement deletes the match; text ends with nothing to send
      write_reg(REG_REPLACEMENT_LENGTH, with_length(0));
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b1);
      wait_idle();

      // bytes held mid-text, then the pattern shrinks under them
      apply_setting(64'h0000_0000_6463_6261, 4, '1, 8);
      send_byte(8'h61, 1'b0);
      send_byte(8'h62, 1'b0);
      send_byte(8'h63, 1'b0);
      wait_idle();
      write_reg(REG_PATTERN_LENGTH, with_length(1));
      send_byte(8'h71, 1'b1);
      wait_idle();

      // index outside the map, then oversized lengths clamp to the maximum
      write_reg(REG_UNUSED, {$urandom, $urandom});
      apply_setting(64'h00FF_00FF_00FF_00FF, 12, {$urandom, $urandom}, 15);
      for (int i = 0; i < 8; i++) send_byte(cfg_pattern[8*i +: 8], i == 7);
      wait_idle();

      tno = 0;
      while (sent < TARGET_ITEMS) begin
         if (tno == 0 || $urandom_range(0, 3) == 0) begin
            wait_idle();
            random_setting();
         end
         idle_on = ($urandom_range(0, 3) != 0);
         if (tno % 9 == 2) hold_requests++;

         // texts rich in whole and partial occurrences of the pattern
         text_q.delete();
         eff  = (cfg_plen > 8) ? 8 : cfg_plen;
         tlen = $urandom_range(1, 20);
         while (text_q.size() < tlen) begin
            r = $urandom_range(0, 9);
            if (eff > 0 && r < 4) begin
               for (int i = 0; i < eff; i++) text_q.push_back(cfg_pattern[8*i +: 8]);
            end else if (eff > 0 && r < 6) begin
               cut = $urandom_range(1, eff);
               for (int i = 0; i < cut; i++) text_q.push_back(cfg_pattern[8*i +: 8]);
            end else if (r < 8) begin
               text_q.push_back(8'(8'h61 + $urandom_range(0, 2)));
            end else begin
               text_q.push_back(8'($urandom_range(0, 255)));
            end
         end

         // now and then the settings change with bytes still held
         cut = ($urandom_range(0, 6) == 0) ? $urandom_range(0, text_q.size() - 1) : -1;
         for (int i = 0; i < text_q.size(); i++) begin
            if (i == cut) begin
               wait_idle();
               random_setting();
            end
            send_byte(text_q[i], i == text_q.size() - 1);
         end
         tno++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Run drove %0d input bytes in %0d texts under %0d register settings,",
               sent, texts_done, settings);
      $display("compared %0d result transactions, with %0d long output hold-offs.",
               checked, hold_requests);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
